### sv/nsl_pkg.sv
`default_nettype none
package nsl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int TAG_WIDTH   = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths fixed by the interface
  localparam int ADDR_W  = 64;
  localparam int NTAG_W  = 16;
  localparam int OFF_W   = 16;
  localparam int USED_W  = 10;
  localparam int LIMIT_W = 17;
  localparam int CMD_W   = 2;

  // one memory word holds tag over start address
  localparam int RAM_W = ADDR_W + TAG_WIDTH;

  localparam logic [LIMIT_W-1:0] LIMIT_CAP = 17'h10000;
  localparam logic [ADDR_W-1:0]  NO_DIST   = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } nsl_state_t;

  // scan datapath control
  typedef struct packed {
    logic init;
    logic vld;
  } nsl_scan_ctl_t;

endpackage
`default_nettype wire

### sv/nsl_in_if.sv
`default_nettype none
interface nsl_in_if
  import nsl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [NTAG_W-1:0] name_tag;

  modport source (output valid, output cmd, output address, output name_tag, input ready);
  modport sink   (input valid, input cmd, input address, input name_tag, output ready);
endinterface
`default_nettype wire

### sv/nsl_out_if.sv
`default_nettype none
interface nsl_out_if
  import nsl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [NTAG_W-1:0] found_tag;
  logic [OFF_W-1:0]  offset;
  logic [USED_W-1:0] entries_used;

  modport source (output valid, output ok, output found_tag, output offset,
                  output entries_used, input ready);
  modport sink   (input valid, input ok, input found_tag, input offset,
                  input entries_used, output ready);
endinterface
`default_nettype wire

### sv/nsl_cfg_if.sv
`default_nettype none
interface nsl_cfg_if
  import nsl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] offset_limit;

  modport source (output valid, output offset_limit, input ready);
  modport sink   (input valid, input offset_limit, output ready);
endinterface
`default_nettype wire

### sv/nsl_ram.sv
`default_nettype none
module nsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/nsl_scan.sv
`default_nettype none
module nsl_scan
  import nsl_pkg::*;
(
  input  wire logic                 clk,
  input  wire nsl_scan_ctl_t        ctl,
  input  wire logic [ADDR_W-1:0]    query,
  input  wire logic [RAM_W-1:0]     rdata,
  output logic      [ADDR_W-1:0]    near_gap_r,
  output logic      [TAG_WIDTH-1:0] best_tag_r
);

  logic [ADDR_W:0]        diff;
  logic [ADDR_W-1:0]      start;
  logic [TAG_WIDTH-1:0]   tag;
  logic                   take;

  assign start = rdata[ADDR_W-1:0];
  assign tag   = rdata[RAM_W-1:ADDR_W];

  // borrow of the subtraction flags a start above the query
  assign diff = {1'b0, query} - {1'b0, start};
  assign take = ctl.vld && !diff[ADDR_W] && (diff[ADDR_W-1:0] < near_gap_r);

  // running nearest entry, strict compare keeps the earliest on ties
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      near_gap_r <= NO_DIST;
      best_tag_r <= '0;
    end else if (take) begin
      near_gap_r <= diff[ADDR_W-1:0];
      best_tag_r <= tag;
    end
  end

endmodule
`default_nettype wire

### sv/nearest_symbol_lookup_table_unit.sv
// insert, clear and unused codes pass through the wait state to the output register, held while out_ch.ready is low
// a lookup first scans the filled entries, then takes the same path; an empty table reads no word
// one item in flight; the lookup scan reads one table word per cycle from the ram
// the next item is taken while a finished result still waits at the output register
// reset (rst_n low, synchronous): table emptied, offset_limit back to 65536, no clearing pass
`default_nettype none
module nearest_symbol_lookup_table_unit
  import nsl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  nsl_in_if.sink     in_ch,
  nsl_out_if.source  out_ch,
  nsl_cfg_if.sink    cfg_ch
);

  nsl_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               rd_vld_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [ADDR_W-1:0]  query_r;

  logic               res_ok_r;
  logic [NTAG_W-1:0]  res_tag_r;
  logic [OFF_W-1:0]   res_off_r;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [NTAG_W-1:0]  out_tag_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [USED_W-1:0]  out_used_r;

  logic               in_fire;
  logic               issue;
  logic               scan_end;
  logic               push;
  logic               ins_ok;
  logic [LIMIT_W-1:0] lim;
  logic               hit;
  logic [RAM_W-1:0]   rdata;
  logic [ADDR_W-1:0]  near_gap;
  logic [TAG_WIDTH-1:0] best_tag;
  nsl_scan_ctl_t      scan_ctl;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign ins_ok   = (fill_r < CNT_W'(TABLE_DEPTH));
  assign issue    = (state_r == S_SCAN) && (idx_r < fill_r);
  assign scan_end = (state_r == S_SCAN) && !issue && !rd_vld_r;
  assign push     = (state_r == S_WAIT) && (!out_valid_r || out_ch.ready);

  // limit capped so the offset always fits its field
  assign lim = (limit_r > LIMIT_CAP) ? LIMIT_CAP : limit_r;
  assign hit = (near_gap < ADDR_W'(lim));

  // table memory: tag over start address
  nsl_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (in_fire && (in_ch.cmd == CMD_INSERT) && ins_ok),
    .waddr(fill_r[IDX_W-1:0]),
    .wdata({TAG_WIDTH'(in_ch.name_tag), in_ch.address}),
    .re   (issue),
    .raddr(idx_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  assign scan_ctl = '{init: in_fire && (in_ch.cmd == CMD_LOOKUP), vld: rd_vld_r};

  nsl_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .query      (query_r),
    .rdata      (rdata),
    .near_gap_r (near_gap),
    .best_tag_r (best_tag)
  );

  // next state, fill count and scan index
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          case (in_ch.cmd)
            CMD_INSERT: begin
              if (ins_ok) begin
                fill_nxt = fill_r + CNT_W'(1);
              end
              state_nxt = S_WAIT;
            end
            CMD_LOOKUP: state_nxt = S_SCAN;
            CMD_CLEAR: begin
              fill_nxt  = '0;
              state_nxt = S_WAIT;
            end
            default: state_nxt = S_WAIT;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (scan_end) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      limit_r     <= LIMIT_CAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= issue;
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.offset_limit;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending result of the current item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      query_r   <= in_ch.address;
      res_tag_r <= '0;
      res_off_r <= '0;
      case (in_ch.cmd)
        CMD_INSERT: res_ok_r <= ins_ok;
        CMD_CLEAR:  res_ok_r <= 1'b1;
        default:    res_ok_r <= 1'b0;
      endcase
    end else if (scan_end) begin
      res_ok_r  <= hit;
      res_tag_r <= hit ? NTAG_W'(best_tag) : '0;
      res_off_r <= hit ? near_gap[OFF_W-1:0] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (push) begin
      out_ok_r   <= res_ok_r;
      out_tag_r  <= res_tag_r;
      out_off_r  <= res_off_r;
      out_used_r <= USED_W'(fill_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.found_tag    = out_tag_r;
  assign out_ch.offset       = out_off_r;
  assign out_ch.entries_used = out_used_r;

endmodule
`default_nettype wire
